FILE: src/ksh_pkg.sv
package ksh_pkg;

    localparam int KSH_WORD_W    = 64;
    localparam int KSH_NBYTES_W  = 4;
    localparam int KSH_COUNT_W   = 8;
    localparam int KSH_CFG_IDX_W = 2;
    localparam int KSH_WORD_BYTES = KSH_WORD_W / 8;

    // register indexes on the config port
    localparam logic [KSH_CFG_IDX_W-1:0] KSH_CFG_KEY_LOW  = 2'd0;
    localparam logic [KSH_CFG_IDX_W-1:0] KSH_CFG_KEY_HIGH = 2'd1;

    // standard initial lane constants
    localparam logic [KSH_WORD_W-1:0] KSH_C0 = 64'h736f6d6570736575;
    localparam logic [KSH_WORD_W-1:0] KSH_C1 = 64'h646f72616e646f6d;
    localparam logic [KSH_WORD_W-1:0] KSH_C2 = 64'h6c7967656e657261;
    localparam logic [KSH_WORD_W-1:0] KSH_C3 = 64'h7465646279746573;

    // value folded into lane 2 before finalization
    localparam logic [KSH_WORD_W-1:0] KSH_FINAL_XOR = 64'h00000000000000ff;

    typedef logic [KSH_WORD_W-1:0] t_word;

    typedef struct packed {
        t_word v0;
        t_word v1;
        t_word v2;
        t_word v3;
    } t_lanes;

    // handoff from the lane stage to the finalization pipe
    typedef struct packed {
        t_lanes lanes;
        t_word  block;
    } t_fin_req;

    function automatic t_word rotl(input t_word x, input int n);
        return (x << n) | (x >> (KSH_WORD_W - n));
    endfunction

    function automatic t_lanes sip_round(input t_lanes s);
        t_lanes r;
        r    = s;
        r.v0 = r.v0 + r.v1;
        r.v2 = r.v2 + r.v3;
        r.v1 = rotl(r.v1, 13);
        r.v3 = rotl(r.v3, 16);
        r.v1 = r.v1 ^ r.v0;
        r.v3 = r.v3 ^ r.v2;
        r.v0 = rotl(r.v0, 32);
        r.v2 = r.v2 + r.v1;
        r.v0 = r.v0 + r.v3;
        r.v1 = rotl(r.v1, 17);
        r.v3 = rotl(r.v3, 21);
        r.v1 = r.v1 ^ r.v2;
        r.v3 = r.v3 ^ r.v0;
        r.v2 = rotl(r.v2, 32);
        return r;
    endfunction

    function automatic t_lanes init_lanes(input t_word k0, input t_word k1);
        t_lanes r;
        r.v0 = k0 ^ KSH_C0;
        r.v1 = k1 ^ KSH_C1;
        r.v2 = k0 ^ KSH_C2;
        r.v3 = k1 ^ KSH_C3;
        return r;
    endfunction

endpackage

FILE: src/ksh_in_if.sv
interface ksh_in_if;
    import ksh_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [KSH_WORD_W-1:0]   data_word;
    logic [KSH_NBYTES_W-1:0] valid_bytes;
    logic                    last_word;

    modport source (output valid, data_word, valid_bytes, last_word, input ready);
    modport sink   (input valid, data_word, valid_bytes, last_word, output ready);
endinterface

FILE: src/ksh_out_if.sv
interface ksh_out_if;
    import ksh_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [KSH_WORD_W-1:0] hash_value;

    modport source (output valid, hash_value, input ready);
    modport sink   (input valid, hash_value, output ready);
endinterface

FILE: src/ksh_compress.sv
module ksh_compress (
    input  ksh_pkg::t_lanes i_lanes,
    input  ksh_pkg::t_word  i_block,
    output ksh_pkg::t_lanes o_lanes
);
    import ksh_pkg::*;

    t_lanes s_pre;
    t_lanes s_post;

    // fold block into lane 3, two rounds, fold into lane 0
    always_comb begin
        s_pre    = i_lanes;
        s_pre.v3 = i_lanes.v3 ^ i_block;
        s_post   = sip_round(sip_round(s_pre));
        o_lanes  = s_post;
        o_lanes.v0 = s_post.v0 ^ i_block;
    end
endmodule

FILE: src/ksh_lane_stage.sv
module ksh_lane_stage (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [ksh_pkg::KSH_CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [ksh_pkg::KSH_WORD_W-1:0]      i_cfg_data,
    ksh_in_if.sink                              i_in,
    output logic                                o_fin_vld,
    input  logic                                i_fin_rdy,
    output ksh_pkg::t_fin_req                   o_fin_req
);
    import ksh_pkg::*;

    logic                    r_in_vld;
    t_word                   r_in_data;
    logic [KSH_NBYTES_W-1:0] r_in_nbytes;
    logic                    r_in_last;

    t_word                   r_key_lo;
    t_word                   r_key_hi;
    t_lanes                  r_lanes;
    logic [KSH_COUNT_W-1:0]  r_count;

    t_lanes                  s_compressed;
    t_lanes                  s_lanes_mid;
    logic                    s_full;
    logic                    s_absorb;
    logic                    s_adv;
    logic [KSH_COUNT_W-1:0]  s_add;
    logic [KSH_COUNT_W-1:0]  n_count;
    t_word                   s_masked;

    // handshake: a non-last item never waits on the finalization pipe
    assign s_adv     = r_in_vld && (!r_in_last || i_fin_rdy);
    assign i_in.ready = !r_in_vld || s_adv;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else begin
            r_in_vld <= (i_in.valid && i_in.ready) || (r_in_vld && !s_adv);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_data   <= i_in.data_word;
            r_in_nbytes <= i_in.valid_bytes;
            r_in_last   <= i_in.last_word;
        end
    end

    // counts above eight saturate; non-last items are always full
    assign s_full   = r_in_nbytes[KSH_NBYTES_W-1] || (r_in_nbytes == KSH_NBYTES_W'(KSH_WORD_BYTES));
    assign s_absorb = !r_in_last || s_full;

    ksh_compress u_compress (
        .i_lanes (r_lanes),
        .i_block (r_in_data),
        .o_lanes (s_compressed)
    );

    assign s_lanes_mid = s_absorb ? s_compressed : r_lanes;

    // byte count and final block
    always_comb begin
        if (s_absorb) begin
            s_add = KSH_COUNT_W'(KSH_WORD_BYTES);
        end else begin
            s_add = KSH_COUNT_W'(r_in_nbytes[2:0]);
        end
        n_count = r_count + s_add;

        s_masked = '0;
        if (!s_full) begin
            for (int b = 0; b < KSH_WORD_BYTES; b++) begin
                if (3'(b) < r_in_nbytes[2:0]) begin
                    s_masked[b*8 +: 8] = r_in_data[b*8 +: 8];
                end
            end
        end
    end

    assign o_fin_vld             = r_in_vld && r_in_last;
    assign o_fin_req.lanes       = s_lanes_mid;
    assign o_fin_req.block       = {n_count, s_masked[KSH_WORD_W-KSH_COUNT_W-1:0]};

    // key registers; a key write reloads the lanes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_lo <= '0;
            r_key_hi <= '0;
            r_lanes  <= init_lanes('0, '0);
            r_count  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                KSH_CFG_KEY_LOW: begin
                    r_key_lo <= i_cfg_data;
                    r_lanes  <= init_lanes(i_cfg_data, r_key_hi);
                    r_count  <= '0;
                end
                KSH_CFG_KEY_HIGH: begin
                    r_key_hi <= i_cfg_data;
                    r_lanes  <= init_lanes(r_key_lo, i_cfg_data);
                    r_count  <= '0;
                end
                default: begin
                end
            endcase
        end else if (s_adv) begin
            if (r_in_last) begin
                r_lanes <= init_lanes(r_key_lo, r_key_hi);
                r_count <= '0;
            end else begin
                r_lanes <= s_compressed;
                r_count <= n_count;
            end
        end
    end
endmodule

FILE: src/ksh_finalize.sv
module ksh_finalize (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fin_vld,
    output logic              o_fin_rdy,
    input  ksh_pkg::t_fin_req i_fin_req,
    ksh_out_if.source         o_out
);
    import ksh_pkg::*;

    logic   r_s1_vld;
    logic   r_s2_vld;
    logic   r_s3_vld;
    logic   r_out_vld;
    t_fin_req r_s1;
    t_lanes r_s2;
    t_lanes r_s3;
    t_word  r_out;

    logic   s_s1_rdy;
    logic   s_s2_rdy;
    logic   s_s3_rdy;
    logic   s_out_rdy;
    t_lanes s_s1_comp;
    t_lanes n_s2;
    t_lanes s_s3_rounds;

    // elastic stage readies
    assign s_out_rdy = !r_out_vld || o_out.ready;
    assign s_s3_rdy  = !r_s3_vld  || s_out_rdy;
    assign s_s2_rdy  = !r_s2_vld  || s_s3_rdy;
    assign s_s1_rdy  = !r_s1_vld  || s_s2_rdy;
    assign o_fin_rdy = s_s1_rdy;

    // stage 1: compress final block, then mark finalization
    ksh_compress u_compress (
        .i_lanes (r_s1.lanes),
        .i_block (r_s1.block),
        .o_lanes (s_s1_comp)
    );

    always_comb begin
        n_s2    = s_s1_comp;
        n_s2.v2 = s_s1_comp.v2 ^ KSH_FINAL_XOR;
    end

    // stage 3 runs the last two rounds
    assign s_s3_rounds = sip_round(sip_round(r_s3));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_s2_vld  <= 1'b0;
            r_s3_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (s_s1_rdy) begin
                r_s1_vld <= i_fin_vld;
            end
            if (s_s2_rdy) begin
                r_s2_vld <= r_s1_vld;
            end
            if (s_s3_rdy) begin
                r_s3_vld <= r_s2_vld;
            end
            if (s_out_rdy) begin
                r_out_vld <= r_s3_vld;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (s_s1_rdy && i_fin_vld) begin
            r_s1 <= i_fin_req;
        end
        if (s_s2_rdy && r_s1_vld) begin
            r_s2 <= n_s2;
        end
        if (s_s3_rdy && r_s2_vld) begin
            r_s3 <= sip_round(sip_round(r_s2));
        end
        if (s_out_rdy && r_s3_vld) begin
            r_out <= s_s3_rounds.v0 ^ s_s3_rounds.v1 ^ s_s3_rounds.v2 ^ s_s3_rounds.v3;
        end
    end

    assign o_out.valid      = r_out_vld;
    assign o_out.hash_value = r_out;
endmodule

FILE: src/keyed_siphash_stream_unit.sv
// SipHash-2-4 over a message streamed as little-endian 64-bit words with a
// 128-bit key written through the config port (index 0 low word, index 1
// high word; any key write restarts the message). One word is accepted every
// cycle unless a last word waits on the finalization pipe; every word
// except the last must carry 8 bytes, the last carries 0 to 8 (values
// above 8 count as 8). The clock is set by the lane loop, which holds two
// rounds between the lane registers. A message end passes an input
// register, a handoff register, a stage that compresses the final block
// and two stages of two rounds each, the second being the output register,
// all moving while the consumer is ready, holding digests in flight if not.
module keyed_siphash_stream_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [ksh_pkg::KSH_CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [ksh_pkg::KSH_WORD_W-1:0]    i_cfg_data,
    ksh_in_if.sink                            i_in,
    ksh_out_if.source                         o_out
);
    import ksh_pkg::*;

    logic     s_fin_vld;
    logic     s_fin_rdy;
    t_fin_req s_fin_req;

    // absorb words into the lanes, hand off each message end
    ksh_lane_stage u_lane_stage (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (i_in),
        .o_fin_vld  (s_fin_vld),
        .i_fin_rdy  (s_fin_rdy),
        .o_fin_req  (s_fin_req)
    );

    // final block, finalization rounds and digest output
    ksh_finalize u_finalize (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_fin_vld (s_fin_vld),
        .o_fin_rdy (s_fin_rdy),
        .i_fin_req (s_fin_req),
        .o_out     (o_out)
    );
endmodule
